// File: hw/rtl/ioc_pkg.sv
// Shared types and constants for the interval overlap clusterer.
// No dependencies; imported by ioc_seq, ioc_out and the top level.
package ioc_pkg;

  // Bit positions inside the result tuser field
  localparam int unsigned USER_RUN_DONE = 0;
  localparam int unsigned USER_OVERFLOW = 1;
  localparam int unsigned USER_W        = 2;

  // Sequencer states, one-hot
  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_RET_RD  = 9'b000000010,
    S_RET_CHK = 9'b000000100,
    S_INS_DEC = 9'b000001000,
    S_INS_RD  = 9'b000010000,
    S_INS_CMP = 9'b000100000,
    S_INS_WR  = 9'b001000000,
    S_EMIT_RD = 9'b010000000,
    S_EMIT_LD = 9'b100000000
  } seq_state_t;

  // Load request from the sequencer to the output register
  typedef struct packed {
    logic load;
    logic cluster_done;
    logic run_done;
    logic overflow;
  } emit_ctl_t;

endpackage

// File: hw/rtl/interval_overlap_clusterer_core.sv
// Interval overlap clusterer, top level.
// Instantiates ioc_seq, ioc_mem and ioc_out; depends on ioc_pkg.
//
// Input stream (s_axis): one interval per transaction, starts nondecreasing.
// tlast marks the final interval of a set; it flushes a last cluster and
// empties the active set. Output stream (m_axis): one cluster member per
// transaction, tlast on the last member of each cluster.
// An item is taken only while the sequencer is idle. Per item the sequencer
// steps through accept, insert decision and write (no write when the
// interval is dropped), plus a read and a check for each active entry
// examined for retirement, a read and a compare for each entry passed by the
// sorted insert, and a read and a load for each emitted member (held while
// m_axis stalls). The registered read of the active-set RAM sets these steps.
// The output register lets the next input be accepted while the last result
// of an item still waits on m_axis_tready; a stalled receiver otherwise holds
// the sequencer in its emit loop with no results lost.
// Reset (rst, synchronous) empties the active set and clears the overflow
// flag; no clearing pass runs, the block is ready the cycle after reset.
module interval_overlap_clusterer_core #(
  parameter int unsigned ACTIVE_CAPACITY = 32,
  parameter int unsigned COORD_WIDTH     = 32,
  parameter int unsigned TAG_WIDTH       = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // tdata, low to high: interval_start, interval_end, member_tag, zero fill
  input  logic [((2*COORD_WIDTH+TAG_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  input  logic s_axis_tlast,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // tdata, low to high: cluster_member, zero fill
  output logic [((TAG_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  output logic m_axis_tlast,
  // tuser, low to high: run_done, overflow_seen
  output logic [ioc_pkg::USER_W-1:0] m_axis_tuser
);
  import ioc_pkg::*;

  localparam int unsigned PW    = (ACTIVE_CAPACITY > 1) ? $clog2(ACTIVE_CAPACITY) : 1;
  localparam int unsigned CW    = $clog2(ACTIVE_CAPACITY + 1);
  localparam int unsigned EW    = COORD_WIDTH + TAG_WIDTH;
  localparam int unsigned OUT_W = ((TAG_WIDTH + 7) / 8) * 8;

  emit_ctl_t             emit;
  logic                  slot_free;
  logic                  mem_wr_en;
  logic [PW-1:0]         mem_wr_addr;
  logic [EW-1:0]         mem_wr_data;
  logic                  mem_rd_en;
  logic [PW-1:0]         mem_rd_addr;
  logic [EW-1:0]         mem_rd_data;
  logic [TAG_WIDTH-1:0]  member;
  logic                  run_done;
  logic                  overflow_seen;

  ioc_seq #(
    .ACTIVE_CAPACITY(ACTIVE_CAPACITY),
    .COORD_WIDTH    (COORD_WIDTH),
    .TAG_WIDTH      (TAG_WIDTH),
    .PW             (PW),
    .CW             (CW)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_start   (s_axis_tdata[COORD_WIDTH-1:0]),
    .in_end     (s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
    .in_tag     (s_axis_tdata[2*COORD_WIDTH+TAG_WIDTH-1:2*COORD_WIDTH]),
    .in_last    (s_axis_tlast),
    .slot_free  (slot_free),
    .emit       (emit),
    .mem_wr_en  (mem_wr_en),
    .mem_wr_addr(mem_wr_addr),
    .mem_wr_data(mem_wr_data),
    .mem_rd_en  (mem_rd_en),
    .mem_rd_addr(mem_rd_addr),
    .mem_rd_data(mem_rd_data)
  );

  ioc_mem #(
    .DEPTH(ACTIVE_CAPACITY),
    .WIDTH(EW),
    .AW   (PW)
  ) u_mem (
    .clk    (clk),
    .wr_en  (mem_wr_en),
    .wr_addr(mem_wr_addr),
    .wr_data(mem_wr_data),
    .rd_en  (mem_rd_en),
    .rd_addr(mem_rd_addr),
    .rd_data(mem_rd_data)
  );

  ioc_out #(
    .TAG_WIDTH(TAG_WIDTH)
  ) u_out (
    .clk          (clk),
    .rst          (rst),
    .emit         (emit),
    .emit_tag     (mem_rd_data[TAG_WIDTH-1:0]),
    .tready       (m_axis_tready),
    .tvalid       (m_axis_tvalid),
    .member       (member),
    .cluster_done (m_axis_tlast),
    .run_done     (run_done),
    .overflow_seen(overflow_seen),
    .slot_free    (slot_free)
  );

  assign m_axis_tdata                = OUT_W'(member);
  assign m_axis_tuser[USER_RUN_DONE] = run_done;
  assign m_axis_tuser[USER_OVERFLOW] = overflow_seen;

endmodule

// File: hw/rtl/ioc_mem.sv
// Active-set storage: single-port-write, single-port-read synchronous RAM.
// Read data is registered. No dependencies.
module ioc_mem #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 48,
  parameter int unsigned AW    = 5
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] ram [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ram[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= ram[rd_addr];
    end
  end

endmodule

// File: hw/rtl/ioc_out.sv
// Result register for the master stream: holds one cluster member until taken.
// Depends on ioc_pkg (emit_ctl_t).
module ioc_out #(
  parameter int unsigned TAG_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ioc_pkg::emit_ctl_t    emit,
  input  logic [TAG_WIDTH-1:0]  emit_tag,
  input  logic                  tready,
  output logic                  tvalid,
  output logic [TAG_WIDTH-1:0]  member,
  output logic                  cluster_done,
  output logic                  run_done,
  output logic                  overflow_seen,
  output logic                  slot_free
);
  import ioc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      tvalid <= 1'b0;
    end else if (emit.load) begin
      tvalid <= 1'b1;
    end else if (tready) begin
      tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.load) begin
      member        <= emit_tag;
      cluster_done  <= emit.cluster_done;
      run_done      <= emit.run_done;
      overflow_seen <= emit.overflow;
    end
  end

  // register is empty after this edge
  assign slot_free = !tvalid || tready;

endmodule

// File: hw/rtl/ioc_seq.sv
// Sequencer: retire, sorted insert and cluster emission over the active-set RAM.
// Active set is a ring (head, count) in ioc_mem. Depends on ioc_pkg.
module ioc_seq #(
  parameter int unsigned ACTIVE_CAPACITY = 32,
  parameter int unsigned COORD_WIDTH     = 32,
  parameter int unsigned TAG_WIDTH       = 16,
  parameter int unsigned PW              = 5,
  parameter int unsigned CW              = 6
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [COORD_WIDTH-1:0]        in_start,
  input  logic [COORD_WIDTH-1:0]        in_end,
  input  logic [TAG_WIDTH-1:0]          in_tag,
  input  logic                          in_last,
  input  logic                          slot_free,
  output ioc_pkg::emit_ctl_t            emit,
  output logic                          mem_wr_en,
  output logic [PW-1:0]                 mem_wr_addr,
  output logic [COORD_WIDTH+TAG_WIDTH-1:0] mem_wr_data,
  output logic                          mem_rd_en,
  output logic [PW-1:0]                 mem_rd_addr,
  input  logic [COORD_WIDTH+TAG_WIDTH-1:0] mem_rd_data
);
  import ioc_pkg::*;

  localparam int unsigned SW = CW + 1;

  seq_state_t state;

  logic [PW-1:0]          head;
  logic [CW-1:0]          count;
  logic [CW-1:0]          pos;
  logic [CW-1:0]          idx;
  logic                   pending;
  logic                   ovf;
  logic                   flush_kind;
  logic [COORD_WIDTH-1:0] start_r;
  logic [COORD_WIDTH-1:0] end_r;
  logic [TAG_WIDTH-1:0]   tag_r;
  logic                   last_r;

  logic [COORD_WIDTH-1:0] rd_end;
  logic                   retire_hit;
  logic                   ins_shift;
  logic                   last_member;
  logic                   at_cap;

  function automatic logic [PW-1:0] ring_addr(input logic [PW-1:0] base,
                                              input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(ACTIVE_CAPACITY)) begin
      sum = sum - SW'(ACTIVE_CAPACITY);
    end
    return sum[PW-1:0];
  endfunction

  assign rd_end      = mem_rd_data[COORD_WIDTH+TAG_WIDTH-1:TAG_WIDTH];
  assign retire_hit  = $signed(rd_end) < $signed(start_r);
  assign ins_shift   = $signed(rd_end) > $signed(end_r);
  assign last_member = (idx == count - CW'(1));
  assign at_cap      = (count >= CW'(ACTIVE_CAPACITY));
  assign in_ready    = (state == S_IDLE);

  // Reads and writes never share a cycle; the FSM orders every access.
  always_comb begin
    mem_rd_en   = 1'b0;
    mem_rd_addr = head;
    mem_wr_en   = 1'b0;
    mem_wr_addr = ring_addr(head, pos);
    mem_wr_data = {end_r, tag_r};
    emit        = '0;
    unique case (state)
      S_RET_RD: begin
        mem_rd_en = 1'b1;
      end
      S_INS_RD: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = ring_addr(head, pos - CW'(1));
      end
      S_INS_CMP: begin
        if (ins_shift) begin
          mem_wr_en   = 1'b1;
          mem_wr_data = mem_rd_data;
        end
      end
      S_INS_WR: begin
        mem_wr_en = 1'b1;
      end
      S_EMIT_RD: begin
        mem_rd_en   = slot_free;
        mem_rd_addr = ring_addr(head, idx);
      end
      S_EMIT_LD: begin
        emit.load         = 1'b1;
        emit.cluster_done = last_member;
        emit.run_done     = last_member && (flush_kind || !last_r);
        emit.overflow     = ovf;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      head    <= '0;
      count   <= '0;
      pending <= 1'b0;
      ovf     <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            start_r <= in_start;
            end_r   <= in_end;
            tag_r   <= in_tag;
            last_r  <= in_last;
            state   <= (count != '0) ? S_RET_RD : S_INS_DEC;
          end
        end
        S_RET_RD: begin
          state <= S_RET_CHK;
        end
        S_RET_CHK: begin
          if (retire_hit) begin
            if (pending) begin
              flush_kind <= 1'b0;
              idx        <= '0;
              state      <= S_EMIT_RD;
            end else begin
              head  <= ring_addr(head, CW'(1));
              count <= count - CW'(1);
              state <= (count == CW'(1)) ? S_INS_DEC : S_RET_RD;
            end
          end else begin
            state <= S_INS_DEC;
          end
        end
        S_INS_DEC: begin
          if (at_cap) begin
            // set is full: drop the interval, pending flag unchanged
            ovf <= 1'b1;
            if (last_r && pending) begin
              flush_kind <= 1'b1;
              idx        <= '0;
              state      <= S_EMIT_RD;
            end else begin
              if (last_r) begin
                count   <= '0;
                head    <= '0;
                pending <= 1'b0;
              end
              state <= S_IDLE;
            end
          end else begin
            pos   <= count;
            state <= (count == '0) ? S_INS_WR : S_INS_RD;
          end
        end
        S_INS_RD: begin
          state <= S_INS_CMP;
        end
        S_INS_CMP: begin
          if (ins_shift) begin
            pos   <= pos - CW'(1);
            state <= (pos == CW'(1)) ? S_INS_WR : S_INS_RD;
          end else begin
            state <= S_INS_WR;
          end
        end
        S_INS_WR: begin
          count   <= count + CW'(1);
          pending <= 1'b1;
          if (last_r) begin
            flush_kind <= 1'b1;
            idx        <= '0;
            state      <= S_EMIT_RD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_EMIT_RD: begin
          if (slot_free) begin
            state <= S_EMIT_LD;
          end
        end
        S_EMIT_LD: begin
          if (last_member) begin
            pending <= 1'b0;
            if (flush_kind) begin
              count <= '0;
              head  <= '0;
              state <= S_IDLE;
            end else begin
              // cluster out; now retire the front entry
              head  <= ring_addr(head, CW'(1));
              count <= count - CW'(1);
              state <= (count == CW'(1)) ? S_INS_DEC : S_RET_RD;
            end
          end else begin
            idx   <= idx + CW'(1);
            state <= S_EMIT_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(ACTIVE_CAPACITY))
    else $error("active count above capacity");

  a_pending_nonempty: assert property (@(posedge clk) disable iff (rst)
    pending |-> (count != '0))
    else $error("insert pending with empty active set");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT_LD) |-> $past(slot_free))
    else $error("result loaded while output register occupied");

  a_insert_room: assert property (@(posedge clk) disable iff (rst)
    (state == S_INS_WR) |-> !at_cap)
    else $error("insert into full active set");

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for interval_overlap_clusterer_core.
// Drives interval transactions, predicts the emitted clusters in SV and compares
// every member transaction. Depends on ioc_pkg and the core RTL only.
`timescale 1ns / 100ps

module testbench;
  import ioc_pkg::*;

  localparam int unsigned CAPACITY     = 32;
  localparam int unsigned COORD_W      = 32;
  localparam int unsigned TAG_W        = 16;
  localparam int          RANDOM_ITEMS = 252;
  localparam int          CALM_ITEMS   = 40;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          DRAIN_CYCLES = 6 * CAPACITY + 20;
  localparam int          LIMIT        = 2_000_000;
  localparam logic [31:0] C_MIN        = 32'h8000_0000;
  localparam logic [31:0] C_MAX        = 32'h7FFF_FFFF;

  typedef enum logic [1:0] {CHECK_PREDICT, CHECK_SILENT, CHECK_SINGLE} row_check_t;

  typedef struct packed {
    logic [31:0] lo;
    logic [31:0] hi;
    logic [15:0] tag;
    logic        last;
    row_check_t  chk;
  } dir_row_t;

  typedef struct packed {
    logic [31:0] end_c;
    logic [15:0] tag;
  } span_t;

  typedef struct packed {
    logic [15:0] member;
    logic        cluster_done;
    logic        run_done;
    logic        overflow;
  } member_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic [USER_W-1:0] m_axis_tuser;

  // predictor state
  span_t       open_spans[$];
  logic        insert_pending = 1'b0;
  logic        overflow_latched = 1'b0;
  member_res_t cluster_batch[$];
  member_res_t expected_members[$];

  int items_taken = 0;
  int mismatches = 0;
  int cycles = 0;
  bit calm_tail = 1'b0;
  bit hold_done = 1'b0;

  // Directed rows: extremes, ties, end below start, out-of-order start, final flush
  dir_row_t directed_rows [18] = '{
    '{32'd0,        32'd10,       16'h0001, 1'b1, CHECK_SINGLE},
    '{C_MIN,        C_MAX,        16'hFFFF, 1'b1, CHECK_SINGLE},
    '{C_MAX,        C_MAX,        16'h0000, 1'b1, CHECK_SINGLE},
    '{C_MIN,        C_MIN,        16'h1234, 1'b0, CHECK_SILENT},
    '{C_MIN,        32'hFFFF_FFFB, 16'h2345, 1'b0, CHECK_SILENT},
    '{32'hFFFF_FFFC, 32'd20,      16'h3456, 1'b0, CHECK_PREDICT},
    '{32'hFFFF_FFFC, 32'hFFFF_FFF6, 16'h4567, 1'b0, CHECK_PREDICT},
    '{32'd100,      32'd200,      16'h5678, 1'b0, CHECK_PREDICT},
    '{32'd50,       32'd60,       16'h6789, 1'b0, CHECK_PREDICT},
    '{32'd60,       32'd200,      16'h789A, 1'b0, CHECK_PREDICT},
    '{32'd60,       32'd200,      16'h89AB, 1'b0, CHECK_PREDICT},
    '{32'd201,      32'd300,      16'h9ABC, 1'b1, CHECK_PREDICT},
    '{32'd5,        32'd5,        16'hAAAA, 1'b0, CHECK_SILENT},
    '{32'd5,        32'd5,        16'h5555, 1'b0, CHECK_SILENT},
    '{32'd6,        32'd7,        16'h0F0F, 1'b0, CHECK_PREDICT},
    '{32'd8,        32'd9,        16'hF0F0, 1'b1, CHECK_PREDICT},
    '{C_MAX,        C_MIN,        16'h7FFF, 1'b0, CHECK_SILENT},
    '{C_MAX,        C_MAX,        16'h8000, 1'b1, CHECK_PREDICT}
  };

  interval_overlap_clusterer_core #(
    .ACTIVE_CAPACITY(CAPACITY),
    .COORD_WIDTH(COORD_W),
    .TAG_WIDTH(TAG_W)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast),
    .m_axis_tuser(m_axis_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic emit_open_spans();
    member_res_t res;
    foreach (open_spans[i]) begin
      res = {open_spans[i].tag, i == open_spans.size() - 1, 1'b0, 1'b0};
      cluster_batch.insert(cluster_batch.size(), res);
    end
  endtask

  // One sweep step: retire below start, sorted insert (dropped when full), flush on final item
  task automatic sweep_item(input logic [31:0] lo, input logic [31:0] hi,
                            input logic [15:0] tag, input logic last);
    int    pos;
    span_t fresh;
    cluster_batch.delete();
    while (open_spans.size() > 0 && $signed(open_spans[0].end_c) < $signed(lo)) begin
      if (insert_pending) begin
        emit_open_spans();
        insert_pending = 1'b0;
      end
      void'(open_spans.pop_front());
    end
    if (open_spans.size() >= CAPACITY) begin
      overflow_latched = 1'b1;
    end else begin
      pos = open_spans.size();
      while (pos > 0 && $signed(open_spans[pos-1].end_c) > $signed(hi))
        pos--;
      fresh.end_c = hi;
      fresh.tag = tag;
      open_spans.insert(pos, fresh);
      insert_pending = 1'b1;
    end
    if (last) begin
      if (insert_pending)
        emit_open_spans();
      open_spans.delete();
      insert_pending = 1'b0;
    end
    foreach (cluster_batch[k])
      cluster_batch[k].overflow = overflow_latched;
    if (cluster_batch.size() > 0)
      cluster_batch[cluster_batch.size()-1].run_done = 1'b1;
  endtask

  task automatic send_item(input logic [31:0] lo, input logic [31:0] hi,
                           input logic [15:0] tag, input logic last, input row_check_t chk);
    s_axis_tdata  <= {tag, hi, lo};
    s_axis_tlast  <= last;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_taken++;
    sweep_item(lo, hi, tag, last);
    case (chk)
      CHECK_PREDICT: foreach (cluster_batch[i])
        expected_members.insert(expected_members.size(), cluster_batch[i]);
      CHECK_SINGLE:  expected_members.insert(expected_members.size(),
                                             {tag, 1'b1, 1'b1, 1'b0});
      default: ;
    endcase
    if (!calm_tail && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // Starts nondecreasing (modulo wrap), mixed spans, some ends below start
  task automatic random_set(input int len, input bit terminate);
    logic [31:0] pos;
    logic [31:0] hi;
    bit          wide;
    pos = $urandom;
    wide = 1'($urandom_range(0, 1));
    for (int i = 0; i < len; i++) begin
      pos = pos + (wide ? $urandom_range(0, 5000) : $urandom_range(0, 8));
      case ($urandom_range(0, 7))
        0: hi = pos - $urandom_range(1, 5);
        1: hi = pos;
        default: hi = pos + (wide ? $urandom_range(0, 20000) : $urandom_range(0, 40));
      endcase
      send_item(pos, hi, 16'($urandom_range(0, 16'hFFFF)), terminate && i == len - 1,
                CHECK_PREDICT);
    end
  endtask

  // Receiver: random stall bursts, one long hold-off to back up the core
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (!hold_done && items_taken >= 60) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (!calm_tail && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // Result checker, one member per transaction
  always @(posedge clk) begin
    member_res_t got;
    member_res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata, m_axis_tlast, m_axis_tuser[USER_RUN_DONE],
             m_axis_tuser[USER_OVERFLOW]};
      if (expected_members.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("cycle %0d: unexpected member %h done %b run %b ovf %b", cycles,
                   got.member, got.cluster_done, got.run_done, got.overflow);
      end else begin
        want = expected_members.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("cycle %0d: expected %h/%b/%b/%b got %h/%b/%b/%b", cycles,
                     want.member, want.cluster_done, want.run_done, want.overflow,
                     got.member, got.cluster_done, got.run_done, got.overflow);
        end
      end
    end
  end

  initial begin
    int  random_sent;
    int  len;
    bit  overflow_done;
    logic [31:0] base;
    random_sent = 0;
    overflow_done = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r])
      send_item(directed_rows[r].lo, directed_rows[r].hi, directed_rows[r].tag,
                directed_rows[r].last, directed_rows[r].chk);

    while (random_sent < RANDOM_ITEMS) begin
      calm_tail = (random_sent >= RANDOM_ITEMS - CALM_ITEMS);
      if (!overflow_done && random_sent >= 150) begin
        // more overlapping intervals than the active set holds
        base = $urandom_range(0, 32'h3FFF_FFFF);
        for (int k = 0; k < 38; k++)
          send_item(base + k, base + 100000, 16'($urandom_range(0, 16'hFFFF)), k == 37,
                    CHECK_PREDICT);
        random_sent += 38;
        overflow_done = 1'b1;
      end else begin
        case ($urandom_range(0, 9))
          0: begin
            send_item($urandom, $urandom, 16'($urandom_range(0, 16'hFFFF)),
                      $urandom_range(0, 3) == 0, CHECK_PREDICT);
            random_sent++;
          end
          1: begin
            // unterminated set, carried into the next one
            len = $urandom_range(1, 6);
            random_set(len, 1'b0);
            random_sent += len;
          end
          default: begin
            len = $urandom_range(1, 12);
            random_set(len, 1'b1);
            random_sent += len;
          end
        endcase
      end
    end
    s_axis_tvalid <= 1'b0;

    while (expected_members.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_members.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/ioc_pkg.sv
hw/rtl/ioc_mem.sv
hw/rtl/ioc_out.sv
hw/rtl/ioc_seq.sv
hw/rtl/interval_overlap_clusterer_core.sv
tb/sv/testbench.sv
